### sv/bosma_pkg.sv
// Shared constants, codes and types for the byte-order swizzled memory access unit.
package bosma_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int BANKS     = 4;
  localparam int MEM_ROWS  = MEM_BYTES / BANKS;
  localparam int ROW_W     = $clog2(MEM_ROWS);

  localparam logic [1:0] ORDER_ABCD = 2'd0;
  localparam logic [1:0] ORDER_DCBA = 2'd2;

  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;

  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [16:0] USED_SIZE_RESET = 17'h10000;

  typedef enum logic {
    REG_BYTE_ORDER = 1'b0,
    REG_USED_SIZE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                   rd_en;
    logic [BANKS-1:0]       we;
    logic [ROW_W-1:0]       row;
    logic [BANKS-1:0][7:0]  wdata;
  } bank_req_t;

endpackage

### sv/bosma_req_if.sv
// Request channel: one memory access word.
interface bosma_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  access_width;
  logic [15:0] address;
  logic [31:0] write_data;

  modport source (output valid, func, access_width, address, write_data, input ready);
  modport sink   (input valid, func, access_width, address, write_data, output ready);
endinterface

### sv/bosma_rsp_if.sv
// Response channel: one result word per access.
interface bosma_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        out_of_range;

  modport source (output valid, read_data, out_of_range, input ready);
  modport sink   (input valid, read_data, out_of_range, output ready);
endinterface

### sv/bosma_banks.sv
// Four byte-wide storage banks, one per physical address lane, with registered reads.
module bosma_banks
  import bosma_pkg::*;
(
  input  logic                  clk,
  input  bank_req_t             ctl,
  output logic [BANKS-1:0][7:0] rdata
);

  logic [7:0] mem [BANKS][MEM_ROWS];

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANKS; b++) begin
      if (ctl.we[b]) begin
        mem[b][ctl.row] <= ctl.wdata[b];
      end
      if (ctl.rd_en) begin
        rdata[b] <= mem[b][ctl.row];
      end
    end
  end

endmodule

### sv/byte_order_swizzled_memory_access.sv
// Byte-order swizzled memory access unit: takes one access word per cycle while the
// response is not stalled, answers via the stage-1 and output registers; four single-port
// byte banks serve a whole aligned word in one access; unwritten bytes read as undefined.
module byte_order_swizzled_memory_access
  import bosma_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  cfg_reg_t     cfg_index,
  input  logic [16:0]  cfg_data,
  bosma_req_if.sink    req,
  bosma_rsp_if.source  rsp
);

  logic [1:0]  byte_order;
  logic [16:0] used_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= ORDER_ABCD;
      used_size  <= USED_SIZE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BYTE_ORDER: byte_order <= cfg_data[1:0];
        REG_USED_SIZE:  used_size  <= cfg_data;
      endcase
    end
  end

  // address swizzle and range check
  logic        abcd, dcba, hi_at;
  logic [1:0]  swz;
  logic [15:0] p;
  logic [2:0]  n;
  logic [31:0] lim;
  logic        err0;
  logic        accept;
  logic [7:0]  lb [4];
  bank_req_t   bank_req;
  logic [BANKS-1:0][7:0] rdata;

  assign abcd  = (byte_order == ORDER_ABCD);
  assign dcba  = (byte_order == ORDER_DCBA);
  assign hi_at = !abcd;
  assign swz   = abcd ? 2'd0 : (dcba ? 2'd3 : 2'd1);

  always_comb begin
    case (req.access_width)
      WIDTH_BYTE: begin
        p = req.address ^ {14'b0, dcba, !abcd};
        n = 3'd1;
      end
      WIDTH_HALF: begin
        p = {req.address[15:1], 1'b0} ^ {14'b0, dcba, 1'b0};
        n = 3'd2;
      end
      default: begin
        p = {req.address[15:2], 2'b00};
        n = 3'd4;
      end
    endcase
    lim  = (32'(used_size) < 32'(MEM_BYTES)) ? 32'(used_size) : 32'(MEM_BYTES);
    err0 = (32'(p) + 32'(n)) > lim;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lb[k] = req.write_data[31 - 8*k -: 8];
    end
    bank_req.rd_en = accept && (req.func != FUNC_WRITE) && !err0;
    bank_req.row   = ROW_W'(p >> 2);
    for (int b = 0; b < BANKS; b++) begin
      case (req.access_width)
        WIDTH_BYTE: begin
          bank_req.wdata[b] = req.write_data[7:0];
          bank_req.we[b]    = (2'(b) == p[1:0]);
        end
        WIDTH_HALF: begin
          bank_req.wdata[b] = (2'(b) == {p[1], hi_at}) ? req.write_data[15:8]
                                                        : req.write_data[7:0];
          bank_req.we[b]    = (2'(b >> 1) == {1'b0, p[1]});
        end
        default: begin
          bank_req.wdata[b] = lb[2'(b) ^ swz];
          bank_req.we[b]    = 1'b1;
        end
      endcase
      bank_req.we[b] = bank_req.we[b] && accept && (req.func == FUNC_WRITE) && !err0;
    end
  end

  bosma_banks u_banks (
    .clk   (clk),
    .ctl   (bank_req),
    .rdata (rdata)
  );

  // stage 1: access in flight, bank data arriving
  logic        s1_valid;
  logic        s1_wr, s1_err, s1_hi;
  logic [1:0]  s1_width, s1_swz, s1_p;
  logic        o_valid;
  logic [31:0] o_read_data;
  logic        o_oor;
  logic        adv;
  logic [31:0] asm_data;

  assign adv       = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr    <= (req.func == FUNC_WRITE);
      s1_err   <= err0;
      s1_hi    <= hi_at;
      s1_width <= req.access_width;
      s1_swz   <= swz;
      s1_p     <= p[1:0];
    end
  end

  always_comb begin
    case (s1_width)
      WIDTH_BYTE: asm_data = {24'b0, rdata[s1_p]};
      WIDTH_HALF: asm_data = {16'b0, rdata[{s1_p[1], s1_hi}], rdata[{s1_p[1], !s1_hi}]};
      default: begin
        for (int k = 0; k < 4; k++) begin
          asm_data[31 - 8*k -: 8] = rdata[2'(k) ^ s1_swz];
        end
      end
    endcase
    if (s1_wr || s1_err) begin
      asm_data = 32'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_read_data <= asm_data;
      o_oor       <= s1_err;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.read_data    = o_read_data;
  assign rsp.out_of_range = o_oor;

`ifndef SYNTHESIS
  a_we_legal: assert property (@(posedge clk) disable iff (rst)
    (|bank_req.we) |-> (accept && !err0 && req.func == FUNC_WRITE))
    else $error("bank write outside a legal accepted write");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_of_range) |-> (rsp.read_data == 32'b0))
    else $error("refused access returned nonzero data");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost before stage 1");
`endif

endmodule

### tb/sv/byte_order_swizzled_memory_access_tb.sv
// Testbench for the byte-order swizzled memory access unit: random traffic checked against a predictor.
module byte_order_swizzled_memory_access_tb
  import bosma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       FUNC_READ   = 1'b0;
  localparam logic [1:0] WIDTH_WORD  = 2'd2;
  localparam logic [1:0] WIDTH_WIDE  = 2'd3;
  localparam logic [1:0] ORDER_BADC  = 2'd1;
  localparam logic [1:0] ORDER_SPARE = 2'd3;
  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 64;

  localparam logic [1:0] PHASE_ORDER [PHASES] = '{ORDER_BADC, ORDER_DCBA, ORDER_ABCD, ORDER_DCBA,
                                                  ORDER_SPARE, ORDER_BADC, ORDER_DCBA, ORDER_ABCD};
  localparam logic [16:0] PHASE_SIZE [PHASES] = '{17'h10000, 17'h1FFFF, 17'h00100, 17'h00102,
                                                  17'h0FFFF, 17'h00000, 17'h00001, 17'h10000};

  typedef struct {
    logic        func;
    logic [1:0]  width;
    logic [15:0] addr;
    logic [31:0] data;
  } access_t;

  typedef struct {
    logic [31:0] read_data;
    logic        out_of_range;
  } result_t;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CADENCE} sink_mode_t;

  class access_scoreboard;
    logic [1:0]  order;
    logic [16:0] used;
    logic [7:0]  store [MEM_BYTES];
    bit          filled [MEM_BYTES];
    result_t     pending_results [$];
    int unsigned errors, reads, writes, refused, matched;

    function new();
      order = ORDER_ABCD;
      used  = USED_SIZE_RESET;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [16:0] value);
      if (idx == REG_BYTE_ORDER) begin
        order = value[1:0];
      end else begin
        used = value;
      end
    endfunction

    function int unsigned reach();
      return (used < MEM_BYTES) ? int'(used) : MEM_BYTES;
    endfunction

    // physical base byte and byte count touched by one access
    function void locate(logic [1:0] width, logic [15:0] addr,
                         output int unsigned base, output int unsigned span);
      if (width == WIDTH_BYTE) begin
        base = 32'(addr);
        if (order != ORDER_ABCD) base = base ^ 1;
        if (order == ORDER_DCBA) base = base ^ 2;
        span = 1;
      end else if (width == WIDTH_HALF) begin
        base = 32'({addr[15:1], 1'b0});
        if (order == ORDER_DCBA) base = base ^ 2;
        span = 2;
      end else begin
        base = 32'({addr[15:2], 2'b00});
        span = 4;
      end
    endfunction

    function bit read_is_safe(logic [1:0] width, logic [15:0] addr);
      int unsigned base, span;
      locate(width, addr, base, span);
      if (base + span > reach()) return 1'b1;
      for (int unsigned i = 0; i < span; i++) begin
        if (!filled[base + i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void predict(logic func, logic [1:0] width, logic [15:0] addr, logic [31:0] data);
      result_t     r;
      int unsigned base, span, hi, swz, loc;
      r.read_data    = '0;
      r.out_of_range = 1'b0;
      locate(width, addr, base, span);
      if (func == FUNC_WRITE) writes++; else reads++;
      if (base + span > reach()) begin
        r.out_of_range = 1'b1;
        refused++;
      end else if (span == 1) begin
        if (func == FUNC_WRITE) begin
          store[base]  = data[7:0];
          filled[base] = 1'b1;
        end else begin
          r.read_data[7:0] = store[base];
        end
      end else if (span == 2) begin
        hi = (order == ORDER_ABCD) ? 0 : 1;
        if (func == FUNC_WRITE) begin
          store[base + hi]        = data[15:8];
          store[base + (hi ^ 1)]  = data[7:0];
          filled[base]            = 1'b1;
          filled[base + 1]        = 1'b1;
        end else begin
          r.read_data[15:0] = {store[base + hi], store[base + (hi ^ 1)]};
        end
      end else begin
        // logical byte k, most significant first, sits at base + (k ^ swz)
        swz = (order == ORDER_ABCD) ? 0 : ((order == ORDER_DCBA) ? 3 : 1);
        for (int unsigned k = 0; k < 4; k++) begin
          loc = base + (k ^ swz);
          if (func == FUNC_WRITE) begin
            store[loc]  = data[8*(3-k)+7 -: 8];
            filled[loc] = 1'b1;
          end else begin
            r.read_data[8*(3-k)+7 -: 8] = store[loc];
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check(logic [31:0] read_data, logic out_of_range);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no access pending: read_data %h out_of_range %b",
               read_data, out_of_range);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (read_data !== want.read_data) begin
        $error("read_data mismatch: expected %h, got %h", want.read_data, read_data);
        errors++;
      end
      if (out_of_range !== want.out_of_range) begin
        $error("out_of_range mismatch: expected %b, got %b", want.out_of_range, out_of_range);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  cfg_reg_t    cfg_index;
  logic [16:0] cfg_data;
  bit          sink_hold_due;

  bosma_req_if req ();
  bosma_rsp_if rsp ();

  access_scoreboard sb = new();

  byte_order_swizzled_memory_access u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req          (req),
    .rsp          (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        sb.predict(req.func, req.access_width, req.address, req.write_data);
      end
      if (rsp.valid && rsp.ready) begin
        sb.check(rsp.read_data, rsp.out_of_range);
      end
    end
  end

  initial begin : response_sink
    sink_mode_t  mode;
    int unsigned mode_left, hold_left, rx_cycle;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    rx_cycle  = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_left == 0 && sink_hold_due) begin
        hold_left     = 120;
        sink_hold_due = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   rsp.ready <= 1'b1;
          SINK_COIN:   rsp.ready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
          default:     rsp.ready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_access(input access_t a);
    req.valid        <= 1'b1;
    req.func         <= a.func;
    req.access_width <= a.width;
    req.address      <= a.addr;
    req.write_data   <= a.data;
    do @(posedge clk); while (req.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [1:0] order, input logic [16:0] size);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_BYTE_ORDER;
    cfg_data     <= {15'd0, order};
    sb.set_reg(REG_BYTE_ORDER, {15'd0, order});
    @(negedge clk);
    cfg_index    <= REG_USED_SIZE;
    cfg_data     <= size;
    sb.set_reg(REG_USED_SIZE, size);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // reads only land on bytes already written or beyond the used size; otherwise the word becomes a write
  function automatic access_t pick_access();
    access_t     a;
    int          near;
    int unsigned pick;
    a.width = ($urandom_range(0, 9) == 0) ? WIDTH_WIDE : 2'($urandom_range(0, 2));
    a.data  = $urandom();
    a.func  = ($urandom_range(0, 99) < 55) ? FUNC_READ : FUNC_WRITE;
    a.addr  = '0;
    for (int tries = 0; tries < 6; tries++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        a.addr = 16'($urandom_range(0, 127));
      end else if (pick < 13) begin
        near = int'(sb.reach()) - 8 + int'($urandom_range(0, 12));
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        a.addr = 16'(near);
      end else if (pick < 17) begin
        a.addr = 16'hFFF0 | 16'($urandom_range(0, 15));
      end else begin
        a.addr = 16'($urandom_range(0, 65535));
      end
      if (a.func == FUNC_WRITE || sb.read_is_safe(a.width, a.addr)) break;
    end
    if (!sb.read_is_safe(a.width, a.addr)) a.func = FUNC_WRITE;
    return a;
  endfunction

  task automatic run_traffic(input int unsigned count);
    int unsigned sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        send_access(pick_access());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin : stimulus
    rst              = 1'b1;
    cfg_write_en     = 1'b0;
    cfg_index        = REG_BYTE_ORDER;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.func         = FUNC_READ;
    req.access_width = WIDTH_BYTE;
    req.address      = '0;
    req.write_data   = '0;
    sink_hold_due    = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset order ABCD: every width, address clearing, top of memory, odd width code
    send_access('{FUNC_WRITE, WIDTH_WORD, 16'h0000, 32'h0123_4567});
    send_access('{FUNC_READ,  WIDTH_WORD, 16'h0000, 32'h0});
    send_access('{FUNC_READ,  WIDTH_HALF, 16'h0000, 32'h0});
    send_access('{FUNC_READ,  WIDTH_HALF, 16'h0002, 32'h0});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'h0000, 32'h0});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'h0001, 32'h0});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'h0002, 32'h0});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'h0003, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_WORD, 16'hFFFC, 32'hFFFF_FFFF});
    send_access('{FUNC_READ,  WIDTH_WORD, 16'hFFFF, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_HALF, 16'hFFFF, 32'h0000_A55A});
    send_access('{FUNC_READ,  WIDTH_HALF, 16'hFFFE, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_BYTE, 16'hFFFF, 32'h0000_00C3});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'hFFFF, 32'h0});
    send_access('{FUNC_READ,  WIDTH_WORD, 16'hFFFC, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_BYTE, 16'h8000, 32'hFFFF_FF80});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'h8000, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_WIDE, 16'h0013, 32'hDEAD_BEEF});
    send_access('{FUNC_READ,  WIDTH_WIDE, 16'h0010, 32'h0});
    send_access('{FUNC_READ,  WIDTH_WORD, 16'h0012, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_HALF, 16'h0021, 32'h0000_BEEF});
    send_access('{FUNC_READ,  WIDTH_HALF, 16'h0020, 32'h0});
    send_access('{FUNC_READ,  WIDTH_BYTE, 16'h0021, 32'h0});
    send_access('{FUNC_WRITE, WIDTH_WORD, 16'h7FFD, 32'h0000_0000});
    send_access('{FUNC_READ,  WIDTH_WORD, 16'h7FFC, 32'h0});

    run_traffic(PHASE_WORDS);
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_regs(PHASE_ORDER[p], PHASE_SIZE[p]);
      // long sink hold while words keep coming, so the input backs up
      if (p == 0 || p == 4) sink_hold_due = 1'b1;
      run_traffic(PHASE_WORDS);
    end
    settle();
    repeat (8) @(negedge clk);

    $display("Covered %0d accesses (%0d reads, %0d writes) over %0d order/size settings;",
             sb.reads + sb.writes, sb.reads, sb.writes, PHASES + 1);
    $display("%0d refused as out of range, %0d results compared, %0d mismatches.",
             sb.refused, sb.matched, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
